### design/vertex_rotate_project_macros.svh
// Assertion macros for the vertex rotate/project block
`ifndef VERTEX_ROTATE_PROJECT_MACROS_SVH
`define VERTEX_ROTATE_PROJECT_MACROS_SVH
// property holds at every edge out of reset
`define VRP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// property checked at every edge including reset
`define VRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### design/vrp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types and constants for the vertex rotate/project block.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int FQ_DEPTH       = 2;
  localparam int TRIG_FRAC_BITS = 14;

  typedef enum logic [2:0] {
    CFG_ROT_Z   = 3'd0,
    CFG_ROT_X   = 3'd1,
    CFG_ROT_Y   = 3'd2,
    CFG_OFS_X   = 3'd3,
    CFG_OFS_Y   = 3'd4,
    CFG_OFS_Z   = 3'd5,
    CFG_FOCAL   = 3'd6,
    CFG_CENTER  = 3'd7
  } cfg_idx_t;

  // beat passed from front to back
  typedef struct packed {
    logic               frame_start;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic signed [15:0] vert_z;
  } vert_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RZ_A,
    ST_RZ_B,
    ST_RX_A,
    ST_RX_B,
    ST_RY_A,
    ST_RY_B,
    ST_OFS,
    ST_PROJ,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } bk_state_t;

endpackage
`default_nettype wire

### design/vrp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_front
// Input side: takes vertex beats and holds them in a short queue.
// ----------------------------------------------------------------------------
module vrp_front import vrp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_frame_start,
  input  wire logic signed [15:0] in_vert_x,
  input  wire logic signed [15:0] in_vert_y,
  input  wire logic signed [15:0] in_vert_z,
  output logic                    fq_valid,
  input  wire logic               fq_pop,
  output vert_beat_t              fq_beat
);

  vert_beat_t mem_r [FQ_DEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok, pop_ok;

  assign in_full      = (cnt_r == 2'(FQ_DEPTH));
  assign push_ok      = in_push && !in_full;
  assign pop_ok       = fq_pop && (cnt_r != 2'd0);
  assign fq_valid     = (cnt_r != 2'd0);
  assign fq_beat      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push_ok;
    rp_nxt  = rp_r ^ pop_ok;
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wp_r] <= '{in_frame_start, in_vert_x, in_vert_y, in_vert_z};
    end
  end

endmodule
`default_nettype wire

### design/vrp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vrp_div import vrp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [35:0] dividend,
  input  wire logic [22:0] divisor,
  output logic             done,
  output logic [35:0]      quotient
);

  logic [35:0] q_r, q_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [22:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [23:0] sh;
  logic [24:0] diff;

  assign done     = busy_r && (cnt_r == 6'd0);
  assign quotient = q_r;

  always_comb begin
    sh       = {rem_r[22:0], q_r[35]};
    diff     = {1'b0, sh} - {2'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'd36;
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r != 6'd0) begin
      cnt_nxt = cnt_r - 6'd1;
      if (!diff[24]) begin
        rem_nxt = diff[23:0];
        q_nxt   = {q_r[34:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[34:0], 1'b0};
      end
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

endmodule
`default_nettype wire

### design/vrp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_back
// Rotation, offset, projection and bounding box; one vertex at a time.
// ----------------------------------------------------------------------------
module vrp_back import vrp_pkg::*; #(
  parameter int DISP_WIDTH  = 320,
  parameter int DISP_HEIGHT = 240
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               fq_valid,
  output logic                    fq_pop,
  input  wire vert_beat_t         fq_beat,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [15:0]      out_screen_x,
  output logic signed [15:0]      out_screen_y,
  output logic signed [23:0]      out_view_depth,
  output logic                    out_behind_viewer,
  output logic signed [15:0]      out_box_min_x,
  output logic signed [15:0]      out_box_max_x,
  output logic signed [15:0]      out_box_min_y,
  output logic signed [15:0]      out_box_max_y
);

  localparam logic signed [15:0] MINX_RST = 16'(DISP_WIDTH + 1);
  localparam logic signed [15:0] MINY_RST = 16'(DISP_HEIGHT + 1);
  localparam logic [31:0] ONE_TRIG = 32'(1) << (16 + TRIG_FRAC_BITS);

  logic [31:0]        rz_r, rx_r, ry_r, ctr_r;
  logic signed [23:0] ox_r, oy_r, oz_r;
  logic [11:0]        foc_r;

  bk_state_t st_r, st_nxt;

  // working registers
  logic signed [20:0] a_r, b_r, c_r;
  logic signed [20:0] ta_r, tb_r;
  logic signed [23:0] vx_r, vy_r, vz_r;
  logic               neg_r;
  logic signed [36:0] num_r;
  logic               ysel_r;
  logic signed [15:0] px_r;
  logic signed [15:0] mnx_r, mxx_r, mny_r, mxy_r;
  logic               ov_r;

  // shared multiplier pair
  logic signed [20:0] m0a, m0b, m1a, m1b;
  logic signed [15:0] tc, tsn;
  logic signed [41:0] p0, p1;
  logic signed [42:0] sum0, sum1;
  logic signed [20:0] sh0;
  logic               swap;

  always_comb begin
    unique case (st_r)
      ST_RZ_A, ST_RZ_B: begin tc = rz_r[31:16]; tsn = rz_r[15:0]; end
      ST_RX_A, ST_RX_B: begin tc = rx_r[31:16]; tsn = rx_r[15:0]; end
      default:          begin tc = ry_r[31:16]; tsn = ry_r[15:0]; end
    endcase
    swap = (st_r == ST_RZ_B) || (st_r == ST_RX_B) || (st_r == ST_RY_B);
    m0a = a_r; m1a = b_r;
    m0b = 21'(tc); m1b = 21'(tsn);
    if (swap) begin
      m0b = 21'(tsn); m1b = 21'(tc);
    end
    p0   = m0a * m0b;
    p1   = m1a * m1b;
    sum0 = swap ? 43'(p0) + 43'(p1) : 43'(p0) - 43'(p1);
    sum1 = sum0 >>> TRIG_FRAC_BITS;
    sh0  = 21'(sum1);
  end

  // projection multiply
  logic signed [24:0] pv;
  logic signed [36:0] prod;
  assign pv   = ysel_r ? -25'(vy_r) : 25'(vx_r);
  assign prod = 37'(pv) * $signed({1'b0, foc_r});

  // offset add with saturation
  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    if (v > 25'sd8388607) return 24'sh7fffff;
    if (v < -25'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  logic signed [24:0] sx25, sy25, sz25;
  assign sx25 = 25'(ta_r) + 25'(ox_r);
  assign sy25 = 25'(c_r) + 25'(oy_r);
  assign sz25 = 25'(tb_r) + 25'(oz_r);

  // divider
  logic        dv_start, dv_done;
  logic [35:0] dv_q, dv_a;
  assign dv_a = neg_r ? 36'(-num_r) : 36'(num_r);

  vrp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_a),
    .divisor  (vz_r[22:0]),
    .done     (dv_done),
    .quotient (dv_q)
  );

  logic signed [37:0] qs, ssum;
  logic signed [15:0] ctr, psat;
  always_comb begin
    qs   = neg_r ? -$signed({2'b0, dv_q}) : $signed({2'b0, dv_q});
    ctr  = ysel_r ? ctr_r[15:0] : ctr_r[31:16];
    ssum = qs + 38'(ctr);
    if (ssum > 38'sd32767) psat = 16'sh7fff;
    else if (ssum < -38'sd32768) psat = 16'sh8000;
    else psat = ssum[15:0];
  end

  logic behind;
  assign behind = (vz_r <= 24'sd0);

  always_comb begin
    st_nxt   = st_r;
    fq_pop   = 1'b0;
    dv_start = 1'b0;
    unique case (st_r)
      ST_IDLE: if (fq_valid) begin
        fq_pop = 1'b1;
        st_nxt = ST_RZ_A;
      end
      ST_RZ_A: st_nxt = ST_RZ_B;
      ST_RZ_B: st_nxt = ST_RX_A;
      ST_RX_A: st_nxt = ST_RX_B;
      ST_RX_B: st_nxt = ST_RY_A;
      ST_RY_A: st_nxt = ST_RY_B;
      ST_RY_B: st_nxt = ST_OFS;
      ST_OFS:  st_nxt = ST_PROJ;
      ST_PROJ: begin
        if (behind) begin
          st_nxt = ST_OUT;
        end else begin
          st_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        dv_start = 1'b1;
        st_nxt   = ST_FIN;
      end
      ST_FIN: if (dv_done) begin
        st_nxt = ysel_r ? ST_OUT : ST_PROJ;
      end
      ST_OUT: if (!ov_r || out_pop) begin
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      ov_r  <= 1'b0;
      rz_r  <= ONE_TRIG;
      rx_r  <= ONE_TRIG;
      ry_r  <= ONE_TRIG;
      ox_r  <= '0;
      oy_r  <= '0;
      oz_r  <= 24'sd800;
      foc_r <= 12'd160;
      ctr_r <= 32'h00A00078;
      mnx_r <= MINX_RST;
      mxx_r <= -16'sd1;
      mny_r <= MINY_RST;
      mxy_r <= -16'sd1;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_idx))
          CFG_ROT_Z:  rz_r  <= cfg_data;
          CFG_ROT_X:  rx_r  <= cfg_data;
          CFG_ROT_Y:  ry_r  <= cfg_data;
          CFG_OFS_X:  ox_r  <= cfg_data[23:0];
          CFG_OFS_Y:  oy_r  <= cfg_data[23:0];
          CFG_OFS_Z:  oz_r  <= cfg_data[23:0];
          CFG_FOCAL:  foc_r <= cfg_data[11:0];
          CFG_CENTER: ctr_r <= cfg_data;
        endcase
      end
      if (st_r == ST_OUT && (!ov_r || out_pop)) begin
        ov_r <= 1'b1;
      end else if (out_pop && ov_r) begin
        ov_r <= 1'b0;
      end
      if (st_r == ST_IDLE && fq_valid && fq_beat.frame_start) begin
        mnx_r <= MINX_RST;
        mxx_r <= -16'sd1;
        mny_r <= MINY_RST;
        mxy_r <= -16'sd1;
      end
      if (st_r == ST_OUT && (!ov_r || out_pop)) begin
        if (!behind) begin
          if (px_r < mnx_r) mnx_r <= px_r;
          if (px_r > mxx_r) mxx_r <= px_r;
          if (psat < mny_r) mny_r <= psat;
          if (psat > mxy_r) mxy_r <= psat;
        end
      end
    end
  end

  logic signed [15:0] bmnx, bmxx, bmny, bmxy;
  always_comb begin
    bmnx = mnx_r; bmxx = mxx_r; bmny = mny_r; bmxy = mxy_r;
    if (!behind) begin
      if (px_r < mnx_r) bmnx = px_r;
      if (px_r > mxx_r) bmxx = px_r;
      if (psat < mny_r) bmny = psat;
      if (psat > mxy_r) bmxy = psat;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        a_r  <= 21'(fq_beat.vert_x);
        b_r  <= 21'(fq_beat.vert_y);
        c_r  <= 21'(fq_beat.vert_z);
      end
      ST_RZ_A: ta_r <= sh0;
      ST_RZ_B: begin
        a_r <= c_r;
        b_r <= sh0;
        c_r <= ta_r;
      end
      ST_RX_A: tb_r <= sh0;
      ST_RX_B: begin
        a_r <= c_r;
        b_r <= tb_r;
        c_r <= sh0;
      end
      ST_RY_A: ta_r <= sh0;
      ST_RY_B: tb_r <= sh0;
      ST_OFS: begin
        vx_r   <= sat24(sx25);
        vy_r   <= sat24(sy25);
        vz_r   <= sat24(sz25);
        ysel_r <= 1'b0;
      end
      ST_PROJ: begin
        num_r <= prod;
        neg_r <= prod[36];
      end
      ST_FIN: if (dv_done) begin
        if (!ysel_r) px_r <= psat;
        ysel_r <= 1'b1;
      end
      ST_OUT: if (!ov_r || out_pop) begin
        out_screen_x      <= behind ? 16'sd0 : px_r;
        out_screen_y      <= behind ? 16'sd0 : psat;
        out_view_depth    <= vz_r;
        out_behind_viewer <= behind;
        out_box_min_x     <= bmnx;
        out_box_max_x     <= bmxx;
        out_box_min_y     <= bmny;
        out_box_max_y     <= bmxy;
      end
      default: ;
    endcase
  end

  assign out_empty = !ov_r;

endmodule
`default_nettype wire

### design/vertex_rotate_project.sv
`default_nettype none
// Path from an accepted input beat to its result beat: input queue, rotation
// through the Z, X and Y states, offset, then per axis a projection multiply,
// divider start and 36-step divide on one shared divider, and the result reg.
// A vertex behind the viewer skips the divides. The back end takes one vertex
// at a time; an unpopped result beat holds it. Two-entry input queue in front.
// Reset (synchronous, rst_n low) loads register defaults and clears the box.
// ----------------------------------------------------------------------------
// vertex_rotate_project
// Euler rotation, view offset and perspective projection with a screen box.
// ----------------------------------------------------------------------------
module vertex_rotate_project import vrp_pkg::*; #(
  parameter int DISP_WIDTH  = 320,
  parameter int DISP_HEIGHT = 240
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               in_frame_start,
  input  wire logic signed [15:0] in_vert_x,
  input  wire logic signed [15:0] in_vert_y,
  input  wire logic signed [15:0] in_vert_z,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      out_screen_x,
  output logic signed [15:0]      out_screen_y,
  output logic signed [23:0]      out_view_depth,
  output logic                    out_behind_viewer,
  output logic signed [15:0]      out_box_min_x,
  output logic signed [15:0]      out_box_max_x,
  output logic signed [15:0]      out_box_min_y,
  output logic signed [15:0]      out_box_max_y
);

  logic       fq_valid;
  logic       fq_pop;
  vert_beat_t fq_beat;

  vrp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (push),
    .in_full        (full),
    .in_frame_start (in_frame_start),
    .in_vert_x      (in_vert_x),
    .in_vert_y      (in_vert_y),
    .in_vert_z      (in_vert_z),
    .fq_valid       (fq_valid),
    .fq_pop         (fq_pop),
    .fq_beat        (fq_beat)
  );

  vrp_back #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_data          (cfg_data),
    .fq_valid          (fq_valid),
    .fq_pop            (fq_pop),
    .fq_beat           (fq_beat),
    .out_empty         (empty),
    .out_pop           (pop),
    .out_screen_x      (out_screen_x),
    .out_screen_y      (out_screen_y),
    .out_view_depth    (out_view_depth),
    .out_behind_viewer (out_behind_viewer),
    .out_box_min_x     (out_box_min_x),
    .out_box_max_x     (out_box_max_x),
    .out_box_min_y     (out_box_min_y),
    .out_box_max_y     (out_box_max_y)
  );

endmodule
`default_nettype wire

### design/vrp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_checker
// Port-level checks on the vertex rotate/project block.
// ----------------------------------------------------------------------------
`include "vertex_rotate_project_macros.svh"
module vrp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic               out_behind_viewer,
  input wire logic signed [15:0] out_screen_x,
  input wire logic signed [15:0] out_screen_y,
  input wire logic signed [23:0] out_view_depth
);
  `VRP_ASSERT(a_behind_zero, clk, rst_n,
    (!empty && out_behind_viewer) |-> (out_screen_x == 16'sd0 && out_screen_y == 16'sd0),
    "behind vertex projected")
  `VRP_ASSERT(a_behind_depth, clk, rst_n,
    !empty |-> (out_behind_viewer == (out_view_depth <= 24'sd0)), "behind flag mismatch")
  `VRP_ASSERT(a_hold, clk, rst_n,
    (!empty && !pop) |=> (!empty && $stable(out_view_depth)), "result dropped")
  `VRP_ASSERT_ALWAYS(a_rst, clk,
    !rst_n |=> (empty && !full), "reset state")
endmodule

bind vertex_rotate_project vrp_checker u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .full              (full),
  .empty             (empty),
  .pop               (pop),
  .out_behind_viewer (out_behind_viewer),
  .out_screen_x      (out_screen_x),
  .out_screen_y      (out_screen_y),
  .out_view_depth    (out_view_depth)
);
`default_nettype wire

### tb/sv/vertex_rotate_project_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_rotate_project_tb
// Drives vertices through the rotate/project block under several register
// settings and flow-control mixes, and checks every result beat against a
// fixed-point projection model kept in the bench or a directed row's table.
// ----------------------------------------------------------------------------
module vertex_rotate_project_tb;
  import vrp_pkg::*;

  localparam int SCR_W = 320;
  localparam int SCR_H = 240;
  localparam int FRAC = 14;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [23:0] depth;
    logic               behind;
    logic signed [15:0] min_x;
    logic signed [15:0] max_x;
    logic signed [15:0] min_y;
    logic signed [15:0] max_y;
  } proj_t;

  typedef struct packed {
    logic               fs;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               chk;
    proj_t              exp;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  logic push = 0;
  logic full;
  logic in_frame_start = 0;
  logic signed [15:0] in_vert_x = '0, in_vert_y = '0, in_vert_z = '0;
  logic empty;
  logic pop = 0;
  logic signed [15:0] out_screen_x, out_screen_y;
  logic signed [23:0] out_view_depth;
  logic out_behind_viewer;
  logic signed [15:0] out_box_min_x, out_box_max_x, out_box_min_y, out_box_max_y;

  vertex_rotate_project dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic [31:0] rz_cs, rx_cs, ry_cs, center;
  logic signed [23:0] ofs_x, ofs_y, ofs_z;
  logic [11:0] focal;
  longint bmin_x, bmax_x, bmin_y, bmax_y;
  proj_t proj_q[$];
  bit    chk_q[$];
  proj_t chk_val_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0, recv_idle = 0;

  function automatic longint fshift(longint v);
    return v >>> FRAC;
  endfunction

  function automatic longint clip(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic proj_t project(logic fs, logic signed [15:0] x,
                                    logic signed [15:0] y, logic signed [15:0] z);
    longint cz, sz, cx, sx, cy, sy, tx, ty, tz, rx, ry, rzz, vx, vy, vz, px, py;
    proj_t r;
    cz = $signed(rz_cs[31:16]); sz = $signed(rz_cs[15:0]);
    cx = $signed(rx_cs[31:16]); sx = $signed(rx_cs[15:0]);
    cy = $signed(ry_cs[31:16]); sy = $signed(ry_cs[15:0]);
    if (fs) begin
      bmin_x = SCR_W + 1; bmax_x = -1; bmin_y = SCR_H + 1; bmax_y = -1;
    end
    tx = fshift(x * cz - y * sz);
    ty = fshift(x * sz + y * cz);
    tz = fshift(z * cx - ty * sx);
    ry = fshift(z * sx + ty * cx);
    rx = fshift(tx * cy - tz * sy);
    rzz = fshift(tx * sy + tz * cy);
    vx = clip(rx + ofs_x, 24);
    vy = clip(ry + ofs_y, 24);
    vz = clip(rzz + ofs_z, 24);
    px = 0; py = 0;
    if (vz > 0) begin
      px = clip(longint'($signed(center[31:16])) + (vx * longint'(focal)) / vz, 16);
      py = clip(longint'($signed(center[15:0])) + (-vy * longint'(focal)) / vz, 16);
      if (px < bmin_x) bmin_x = px;
      if (px > bmax_x) bmax_x = px;
      if (py < bmin_y) bmin_y = py;
      if (py > bmax_y) bmax_y = py;
    end
    r.sx = 16'(px); r.sy = 16'(py); r.depth = 24'(vz); r.behind = (vz <= 0);
    r.min_x = 16'(bmin_x); r.max_x = 16'(bmax_x);
    r.min_y = 16'(bmin_y); r.max_y = 16'(bmax_y);
    return r;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_ROT_Z:  rz_cs = val;
      CFG_ROT_X:  rx_cs = val;
      CFG_ROT_Y:  ry_cs = val;
      CFG_OFS_X:  ofs_x = val[23:0];
      CFG_OFS_Y:  ofs_y = val[23:0];
      CFG_OFS_Z:  ofs_z = val[23:0];
      CFG_FOCAL:  focal = val[11:0];
      CFG_CENTER: center = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    push <= 0;
    while (proj_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_vertex(logic fs, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, bit typed, proj_t typed_val);
    proj_t p;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1; in_frame_start <= fs; in_vert_x <= x; in_vert_y <= y; in_vert_z <= z;
    @(posedge clk);
    while (full) @(posedge clk);
    p = project(fs, x, y, z);
    proj_q.push_back(p);
    chk_q.push_back(typed);
    chk_val_q.push_back(typed_val);
  endtask

  // receive side
  always @(posedge clk) begin
    proj_t got, want, typed_val;
    bit typed;
    if (rst_n) begin
      if (pop && !empty) begin
        got = {out_screen_x, out_screen_y, out_view_depth, out_behind_viewer,
               out_box_min_x, out_box_max_x, out_box_min_y, out_box_max_y};
        if (proj_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = proj_q.pop_front();
          typed = chk_q.pop_front();
          typed_val = chk_val_q.pop_front();
          if (typed && typed_val != want) want = typed_val;
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp %h got %h (sx %0d/%0d sy %0d/%0d z %0d/%0d)",
                       want, got, want.sx, got.sx, want.sy, got.sy, want.depth,
                       got.depth);
          end
        end
      end
      pop <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[vertex_rotate_project] ERROR");
      $finish;
    end
  end

  function automatic proj_t mk(int sx, int sy, int d, bit b, int a, int bb, int c, int e);
    proj_t r;
    r.sx = 16'(sx); r.sy = 16'(sy); r.depth = 24'(d); r.behind = b;
    r.min_x = 16'(a); r.max_x = 16'(bb); r.min_y = 16'(c); r.max_y = 16'(e);
    return r;
  endfunction

  function automatic row_t row(logic fs, int x, int y, int z, bit chk, proj_t e);
    row_t r;
    r.fs = fs; r.x = 16'(x); r.y = 16'(y); r.z = 16'(z); r.chk = chk; r.exp = e;
    return r;
  endfunction

  row_t dir_rows[$];

  function automatic logic [31:0] rand_trig();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(3))
      0: v = {16'sd16384, 16'sd0};
      1: v = {16'sh8000, 16'sh7fff};
      default: v = {16'($urandom_range(32767) - 16384), 16'($urandom_range(32767) - 16384)};
    endcase
    return v;
  endfunction

  initial begin
    proj_t none;
    int phase;
    none = '0;
    rz_cs = 32'h4000_0000; rx_cs = 32'h4000_0000; ry_cs = 32'h4000_0000;
    ofs_x = 0; ofs_y = 0; ofs_z = 800; focal = 160; center = 32'h00A0_0078;
    bmin_x = SCR_W + 1; bmax_x = -1; bmin_y = SCR_H + 1; bmax_y = -1;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // origin lands on the screen center
    dir_rows.push_back(row(1, 0, 0, 0, 1, mk(160, 120, 800, 0, 160, 160, 120, 120)));
    dir_rows.push_back(row(0, 100, 0, 0, 1, mk(180, 120, 800, 0, 160, 180, 120, 120)));
    dir_rows.push_back(row(0, 0, 100, 0, 1, mk(160, 100, 800, 0, 160, 180, 100, 120)));
    // behind viewer leaves the box alone
    dir_rows.push_back(row(0, 0, 0, -800, 1, mk(0, 0, 0, 1, 160, 180, 100, 120)));
    dir_rows.push_back(row(0, 0, 0, -32768, 1, mk(0, 0, -31968, 1, 160, 180, 100, 120)));
    dir_rows.push_back(row(1, 0, 0, -900, 1, mk(0, 0, -100, 1, 321, -1, 241, -1)));
    // huge coordinates saturate on screen
    dir_rows.push_back(row(0, 32767, 0, -799, 1, mk(32767, 120, 1, 0, 321, 32767, 120, 120)));
    dir_rows.push_back(row(0, -32768, -32768, -799, 1,
                           mk(-32768, 32767, 1, 0, -32768, 32767, 120, 32767)));
    dir_rows.push_back(row(1, 32767, 32767, 32767, 0, none));
    dir_rows.push_back(row(0, -32768, 32767, -32768, 0, none));
    dir_rows.push_back(row(0, 1234, -4321, 55, 0, none));
    foreach (dir_rows[i])
      send_vertex(dir_rows[i].fs, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                  dir_rows[i].chk, dir_rows[i].exp);
    drain();

    // extremes of every register, zero focal gives the center
    write_reg(CFG_ROT_Z, {16'sh8000, 16'sh7fff});
    write_reg(CFG_ROT_X, {16'sh7fff, 16'sh8000});
    write_reg(CFG_ROT_Y, 32'hFFFF_FFFF);
    write_reg(CFG_OFS_X, 32'h7F_FFFF);
    write_reg(CFG_OFS_Y, 32'h80_0000);
    write_reg(CFG_OFS_Z, 32'h7F_FFFF);
    write_reg(CFG_FOCAL, 32'h0);
    write_reg(CFG_CENTER, 32'h8000_7FFF);
    send_vertex(1, 0, 0, 0, 0, none);
    send_vertex(0, -32768, 32767, 1, 0, none);
    drain();
    write_reg(CFG_FOCAL, 32'hFFF);
    send_vertex(0, 32767, -32768, -1, 0, none);
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 75; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 75; end
        default: begin send_idle = 18; recv_idle = 18; end
      endcase
      write_reg(CFG_ROT_Z, rand_trig());
      write_reg(CFG_ROT_X, rand_trig());
      write_reg(CFG_ROT_Y, rand_trig());
      write_reg(CFG_OFS_X, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000) - 1000);
      write_reg(CFG_OFS_Y, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000) - 1000);
      write_reg(CFG_OFS_Z, $urandom_range(3) == 0 ? $urandom : $urandom_range(40000));
      write_reg(CFG_FOCAL, $urandom_range(4095));
      write_reg(CFG_CENTER, $urandom_range(3) == 0 ? $urandom
                : {16'($urandom_range(320)), 16'($urandom_range(240))});
      for (int k = 0; k < 105; k++) begin
        logic signed [15:0] vx, vy, vz;
        if ($urandom_range(3) == 0) begin
          vx = 16'($urandom); vy = 16'($urandom); vz = 16'($urandom);
        end else begin
          vx = 16'($urandom_range(400) - 200);
          vy = 16'($urandom_range(400) - 200);
          vz = 16'($urandom_range(400) - 200);
        end
        send_vertex($urandom_range(15) == 0, vx, vy, vz, 0, none);
        if (k == 50 && phase == 1) begin
          push <= 0;
          while (proj_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("[vertex_rotate_project] OK");
    end else begin
      $display("[vertex_rotate_project] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
